// ===== sv/gmgp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gold mine grid path block.
// No dependencies; the other files that use it refer to it by scoped names.
package gmgp_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);

    localparam int GOLD_W    = 16;
    localparam int SUM_W     = 21;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_POS_W = 5;

    localparam int RESET_ROWS = 4;
    localparam int RESET_COLS = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic KIND_TOTAL = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    typedef enum logic [1:0] {
        PICK_STRAIGHT = 2'd0,
        PICK_UP       = 2'd1,
        PICK_DOWN     = 2'd2
    } t_pick;

    // Effective grid size, held as last row and last column index
    typedef struct packed {
        logic [ROW_W-1:0] rows_last;
        logic [COL_W-1:0] cols_last;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] gold;
        logic [SUM_W-1:0] st;
        logic [SUM_W-1:0] up;
        logic [SUM_W-1:0] dn;
        logic             top;
        logic             bottom;
        logic             last_col;
    } t_cell_in;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_pick            pick;
    } t_cell_out;

endpackage

// ===== sv/gmgp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gmgp_cell.sv =====
`timescale 1ns / 1ps
// Shared cell unit: picks the best successor with the edge-row tie rules,
// adds it to the cell's gold and saturates. Depends on gmgp_pkg.
module gmgp_cell (
    input  gmgp_pkg::t_cell_in  i_cell,
    output gmgp_pkg::t_cell_out o_cell
);

    gmgp_pkg::t_pick              pick;
    logic [gmgp_pkg::SUM_W-1:0]   add;
    logic [gmgp_pkg::SUM_W:0]     sum_full;

    always_comb begin
        if (i_cell.last_col) begin
            pick = gmgp_pkg::PICK_STRAIGHT;
        end else if (i_cell.top) begin
            pick = (i_cell.st > i_cell.dn) ? gmgp_pkg::PICK_STRAIGHT : gmgp_pkg::PICK_DOWN;
        end else if (i_cell.bottom) begin
            pick = (i_cell.st > i_cell.up) ? gmgp_pkg::PICK_STRAIGHT : gmgp_pkg::PICK_UP;
        end else if (i_cell.st >= i_cell.dn && i_cell.st >= i_cell.up) begin
            pick = gmgp_pkg::PICK_STRAIGHT;
        end else if (i_cell.up >= i_cell.st && i_cell.up >= i_cell.dn) begin
            pick = gmgp_pkg::PICK_UP;
        end else begin
            pick = gmgp_pkg::PICK_DOWN;
        end

        case (pick)
            gmgp_pkg::PICK_UP:   add = i_cell.up;
            gmgp_pkg::PICK_DOWN: add = i_cell.dn;
            default:             add = i_cell.st;
        endcase
        if (i_cell.last_col) begin
            add = '0;
        end

        sum_full = {1'b0, i_cell.gold} + {1'b0, add};
        o_cell.pick = pick;
        o_cell.sum  = sum_full[gmgp_pkg::SUM_W] ? gmgp_pkg::SUM_MAX
                                                : sum_full[gmgp_pkg::SUM_W-1:0];
    end

endmodule

// ===== sv/gmgp_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: grid load, right-to-left column sweep through the shared cell
// unit, best-cell tracking and path emission. Depends on gmgp_pkg,
// gmgp_ram and gmgp_cell.
module gmgp_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gmgp_pkg::t_cfg                    i_cfg,
    input  logic                              i_cfg_wr,
    input  logic                              i_valid,
    input  logic [gmgp_pkg::GOLD_W-1:0]       i_gold,
    output logic                              o_stall,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_kind,
    output logic [gmgp_pkg::SUM_W-1:0]        o_total,
    output logic [gmgp_pkg::OUT_POS_W-1:0]    o_row,
    output logic [gmgp_pkg::OUT_POS_W-1:0]    o_col,
    output logic                              o_last
);

    typedef enum logic [2:0] {
        S_LOAD, S_PRE0, S_PRE1, S_CB, S_CC, S_TOT, S_RD, S_STEP
    } t_state;

    t_state                          r_state, n_state;
    logic [gmgp_pkg::ROW_W-1:0]      r_row, n_row;
    logic [gmgp_pkg::COL_W-1:0]      r_col, n_col;
    logic [gmgp_pkg::SUM_W-1:0]      r_win_up, n_win_up;
    logic [gmgp_pkg::SUM_W-1:0]      r_win_st, n_win_st;
    logic [gmgp_pkg::SUM_W-1:0]      r_win_dn, n_win_dn;
    logic [gmgp_pkg::SUM_W-1:0]      r_best_total, n_best_total;
    logic [gmgp_pkg::ROW_W-1:0]      r_best_row, n_best_row;
    logic [gmgp_pkg::COL_W-1:0]      r_best_col, n_best_col;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_kind, n_out_kind;
    logic [gmgp_pkg::SUM_W-1:0]      r_out_total, n_out_total;
    logic [gmgp_pkg::OUT_POS_W-1:0]  r_out_row, n_out_row;
    logic [gmgp_pkg::OUT_POS_W-1:0]  r_out_col, n_out_col;
    logic                            r_out_last, n_out_last;

    logic                            in_acc;
    logic                            out_free;
    logic                            last_col;
    logic [gmgp_pkg::COL_W-1:0]      col_nx;
    logic [gmgp_pkg::ROW_W:0]        row_p2;

    logic                            sum_we, sum_re, ch_we, ch_re;
    logic [gmgp_pkg::ADDR_W-1:0]     sum_raddr, cell_addr;
    logic [gmgp_pkg::SUM_W-1:0]      sum_wdata, sum_rdata;
    logic [1:0]                      ch_rdata;
    gmgp_pkg::t_pick                 step_pick;
    gmgp_pkg::t_cell_in              cell_in;
    gmgp_pkg::t_cell_out             cell_out;

    assign o_stall   = (r_state != S_LOAD) || i_cfg_wr;
    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign last_col  = (r_col == i_cfg.cols_last);
    assign col_nx    = r_col + 1'b1;
    assign row_p2    = {1'b0, r_row} + (gmgp_pkg::ROW_W+1)'(2);
    assign cell_addr = {r_row, r_col};
    assign step_pick = gmgp_pkg::t_pick'(ch_rdata);

    assign cell_in.gold     = sum_rdata;
    assign cell_in.st       = r_win_st;
    assign cell_in.up       = r_win_up;
    assign cell_in.dn       = r_win_dn;
    assign cell_in.top      = (r_row == '0);
    assign cell_in.bottom   = (r_row == i_cfg.rows_last);
    assign cell_in.last_col = last_col;

    gmgp_cell u_cell (
        .i_cell (cell_in),
        .o_cell (cell_out)
    );

    gmgp_ram #(
        .WIDTH (gmgp_pkg::SUM_W),
        .DEPTH (gmgp_pkg::DEPTH)
    ) u_sum_store (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (cell_addr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    gmgp_ram #(
        .WIDTH (2),
        .DEPTH (gmgp_pkg::DEPTH)
    ) u_choice_store (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (cell_addr),
        .i_wdata (cell_out.pick),
        .i_re    (ch_re),
        .i_raddr (cell_addr),
        .o_rdata (ch_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_win_up     = r_win_up;
        n_win_st     = r_win_st;
        n_win_dn     = r_win_dn;
        n_best_total = r_best_total;
        n_best_row   = r_best_row;
        n_best_col   = r_best_col;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_total  = r_out_total;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;
        sum_we       = 1'b0;
        sum_re       = 1'b0;
        ch_we        = 1'b0;
        ch_re        = 1'b0;
        sum_raddr    = cell_addr;
        sum_wdata    = cell_out.sum;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                sum_wdata = gmgp_pkg::SUM_W'(i_gold);
                if (in_acc) begin
                    sum_we = 1'b1;
                    if (last_col) begin
                        n_col = '0;
                        if (r_row == i_cfg.rows_last) begin
                            // grid complete: start the sweep at the last column
                            n_row   = '0;
                            n_col   = i_cfg.cols_last;
                            n_state = S_CB;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = col_nx;
                    end
                end else if (i_cfg_wr) begin
                    // drop a partial load
                    n_row = '0;
                    n_col = '0;
                end
            end
            S_PRE0: begin
                sum_re    = 1'b1;
                sum_raddr = {gmgp_pkg::ROW_W'(0), col_nx};
                n_state   = S_PRE1;
            end
            S_PRE1: begin
                n_win_st  = sum_rdata;
                sum_re    = 1'b1;
                sum_raddr = {gmgp_pkg::ROW_W'(1), col_nx};
                n_state   = S_CB;
            end
            S_CB: begin
                if (!last_col) begin
                    n_win_dn = sum_rdata;
                end
                sum_re    = 1'b1;
                sum_raddr = cell_addr;
                n_state   = S_CC;
            end
            S_CC: begin
                sum_we   = 1'b1;
                ch_we    = 1'b1;
                n_win_up = r_win_st;
                n_win_st = r_win_dn;
                if ((last_col && r_row == '0) || cell_out.sum > r_best_total) begin
                    n_best_total = cell_out.sum;
                    n_best_row   = r_row;
                    n_best_col   = r_col;
                end
                // prefetch the down-right total for the next row
                if (!last_col && row_p2 <= {1'b0, i_cfg.rows_last}) begin
                    sum_re    = 1'b1;
                    sum_raddr = {row_p2[gmgp_pkg::ROW_W-1:0], col_nx};
                end
                if (r_row == i_cfg.rows_last) begin
                    n_row = '0;
                    if (r_col == '0) begin
                        n_state = S_TOT;
                    end else begin
                        n_col   = r_col - 1'b1;
                        n_state = S_PRE0;
                    end
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_CB;
                end
            end
            S_TOT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = gmgp_pkg::KIND_TOTAL;
                    n_out_total = r_best_total;
                    n_out_row   = gmgp_pkg::OUT_POS_W'(r_best_row);
                    n_out_col   = gmgp_pkg::OUT_POS_W'(r_best_col);
                    n_out_last  = 1'b0;
                    n_row       = r_best_row;
                    n_col       = r_best_col;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                ch_re   = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = gmgp_pkg::KIND_STEP;
                    n_out_total = '0;
                    n_out_row   = gmgp_pkg::OUT_POS_W'(r_row);
                    n_out_col   = gmgp_pkg::OUT_POS_W'(r_col);
                    n_out_last  = last_col;
                    if (step_pick == gmgp_pkg::PICK_UP && r_row != '0) begin
                        n_row = r_row - 1'b1;
                    end else if (step_pick == gmgp_pkg::PICK_DOWN &&
                                 r_row != i_cfg.rows_last) begin
                        n_row = r_row + 1'b1;
                    end
                    if (last_col) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_col   = col_nx;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_row        <= '0;
            r_col        <= '0;
            r_best_total <= '0;
            r_best_row   <= '0;
            r_best_col   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_best_total <= n_best_total;
            r_best_row   <= n_best_row;
            r_best_col   <= n_best_col;
            r_out_valid  <= n_out_valid;
        end
        r_win_up    <= n_win_up;
        r_win_st    <= n_win_st;
        r_win_dn    <= n_win_dn;
        r_out_kind  <= n_out_kind;
        r_out_total <= n_out_total;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_total = r_out_total;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

    a_sweep_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CC) |-> (r_row <= i_cfg.rows_last))
        else $error("sweep row beyond the grid");

    a_total_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == gmgp_pkg::KIND_TOTAL) |-> !r_out_last)
        else $error("total transaction flagged as last");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && out_free && last_col) |=> (r_state == S_LOAD && r_out_last))
        else $error("final path step did not return to loading");

    a_no_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last && !i_stall) |=> !r_out_valid)
        else $error("result issued after the final path step");

endmodule

// ===== sv/gold_mine_grid_path_dp_top.sv =====
`timescale 1ns / 1ps
// Gold mine grid path search, top level. Depends on gmgp_pkg and gmgp_seq.
// After the last cell is loaded the sweep passes each cell through S_CB and
// S_CC, with S_PRE0 and S_PRE1 ahead of each column left of the last, through
// one shared cell unit and the single read port of the sum store; emission
// gives the total, then the path steps. Reset is synchronous: grid size
// returns to 4 by 4, control clears, the stores are not cleared.
module gold_mine_grid_path_dp_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [gmgp_pkg::GOLD_W-1:0]         i_gold,
    output logic                                o_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_kind,
    output logic [gmgp_pkg::SUM_W-1:0]          o_total,
    output logic [gmgp_pkg::OUT_POS_W-1:0]      o_row,
    output logic [gmgp_pkg::OUT_POS_W-1:0]      o_col,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gmgp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gmgp_pkg::CFG_W-1:0]          i_cfg_data
);

    gmgp_pkg::t_cfg r_cfg, n_cfg;
    logic           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Clamp written sizes into the supported range and keep them as last indexes
    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                gmgp_pkg::CFG_ROW_COUNT: begin
                    if (i_cfg_data < gmgp_pkg::CFG_W'(2)) begin
                        n_cfg.rows_last = gmgp_pkg::ROW_W'(1);
                    end else if ({1'b0, i_cfg_data} > (gmgp_pkg::CFG_W+1)'(gmgp_pkg::MAX_ROWS)) begin
                        n_cfg.rows_last = gmgp_pkg::ROW_W'(gmgp_pkg::MAX_ROWS - 1);
                    end else begin
                        n_cfg.rows_last = gmgp_pkg::ROW_W'(i_cfg_data - 1'b1);
                    end
                end
                gmgp_pkg::CFG_COLUMN_COUNT: begin
                    if (i_cfg_data == '0) begin
                        n_cfg.cols_last = '0;
                    end else if ({1'b0, i_cfg_data} > (gmgp_pkg::CFG_W+1)'(gmgp_pkg::MAX_COLS)) begin
                        n_cfg.cols_last = gmgp_pkg::COL_W'(gmgp_pkg::MAX_COLS - 1);
                    end else begin
                        n_cfg.cols_last = gmgp_pkg::COL_W'(i_cfg_data - 1'b1);
                    end
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_last <= gmgp_pkg::ROW_W'(gmgp_pkg::RESET_ROWS - 1);
            r_cfg.cols_last <= gmgp_pkg::COL_W'(gmgp_pkg::RESET_COLS - 1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gmgp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .i_valid  (i_valid),
        .i_gold   (i_gold),
        .o_stall  (o_stall),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_kind   (o_kind),
        .o_total  (o_total),
        .o_row    (o_row),
        .o_col    (o_col),
        .o_last   (o_last)
    );

endmodule
